// ----- rtl/core/sync_ack_window_assert.svh -----
// Assertion macros for the ack window block.
`ifndef SYNC_ACK_WINDOW_ASSERT_SVH
`define SYNC_ACK_WINDOW_ASSERT_SVH
`ifndef SYNTH
`define SAW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SAW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SAW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SAW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/saw_pkg.sv -----
package saw_pkg;
    localparam int STORE_DEPTH = 1024;
    localparam int OFFSET_BITS = 48;
    localparam int IDX_BITS = $clog2(STORE_DEPTH);
    localparam int CNT_BITS = IDX_BITS + 1;
    localparam int WS_BITS = 11;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ACK_FAIL = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_ACK = 1'b1;

    typedef logic [OFFSET_BITS-1:0] ofs_t;
    typedef logic [IDX_BITS-1:0] idx_t;
    typedef logic [CNT_BITS-1:0] cnt_t;

    // Memory access request from the sequencer to the entry store.
    typedef struct packed {
        logic rd_en;
        idx_t rd_addr;
        logic wr_en;
        idx_t wr_addr;
        ofs_t wr_key;
        logic wr_acked;
    } mem_req_t;
endpackage

// ----- rtl/core/saw_store.sv -----
module saw_store
    import saw_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output ofs_t     rd_key,
    output logic     rd_acked
);
    ofs_t key_mem [STORE_DEPTH];
    logic acked_mem [STORE_DEPTH];

    // Every entry inside the occupancy was written when it was inserted, so
    // neither array needs a reset.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            key_mem[req.wr_addr] <= req.wr_key;
            acked_mem[req.wr_addr] <= req.wr_acked;
        end
        if (req.rd_en)
        begin
            rd_key <= key_mem[req.rd_addr];
            rd_acked <= acked_mem[req.rd_addr];
        end
    end
endmodule

// ----- rtl/core/sync_ack_window.sv -----
// Ack window tracker. One command word is taken when start is high and busy
// is low; busy then stays high while a small sequencer walks the entry store
// through one read port and one write port, a read state then a check or
// write state per entry visited. A push searches for its position and shifts
// the entries behind it, after a front-drop walk when pruning runs; an ack
// makes up to two full scans of the window for the range search, then one
// pass over the marked range and one over the slid-off front. The number of
// entries visited thus grows with the occupancy, up to a full 1024-entry
// store. The result word appears for exactly one cycle with done high; the
// receiver cannot stall it, so it must take every word in the cycle it is
// shown.
// Window size may be written over the cfg channel only while busy is low.
module sync_ack_window
    import saw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic [47:0]        offset,
    input  logic [47:0]        start_offset,
    output logic               done,
    output logic [1:0]         status,
    output logic               acked_valid,
    output logic [47:0]        confirmed_offset,
    output logic [10:0]        remaining,
    output logic [10:0]        occupancy,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [10:0]        cfg_data
);
    `include "sync_ack_window_assert.svh"

    typedef enum logic [4:0] {
        S_IDLE, S_PR_RD, S_PR_CHK, S_PR_CUT,
        S_PS_RD, S_PS_CHK, S_SH_RD, S_SH_WR, S_INS,
        S_AK_RD0, S_AK_CHK0, S_FD_RD, S_FD_CHK, S_RANGE,
        S_MK_RD, S_MK_WR, S_SL_RD, S_SL_CHK, S_DONE
    } state_t;

    state_t state_reg;
    logic [WS_BITS-1:0] ws_reg;
    idx_t head_reg;
    cnt_t count_reg;
    cnt_t i_reg;      // walk position
    cnt_t sp_reg, ep_reg;
    logic fnd_s_reg, fnd_e_reg;
    logic scan_e_reg; // second search pass looks for the end key
    logic func_reg;
    ofs_t k_reg, s_reg;
    logic [1:0] status_reg;
    logic valid_reg;
    ofs_t acked_reg;
    logic done_reg;

    mem_req_t req;
    ofs_t rd_key;
    logic rd_acked;

    saw_store u_store (
        .clk(clk), .req(req),
        .rd_key(rd_key), .rd_acked(rd_acked)
    );

    function automatic idx_t slot(idx_t h, cnt_t i);
        slot = h + i[IDX_BITS-1:0];
    endfunction

    // Pruning thresholds, one wide compare each.
    logic [CNT_BITS+4:0] cnt10, cnt5;
    logic [WS_BITS+4:0] ws9, ws4;
    assign cnt10 = {4'd0, count_reg, 1'b0} + {2'd0, count_reg, 3'b0};
    assign cnt5  = {5'd0, count_reg} + {3'd0, count_reg, 2'b0};
    assign ws9   = {5'd0, ws_reg} + {2'd0, ws_reg, 3'b0};
    assign ws4   = {3'd0, ws_reg, 2'b0};

    // count/5 by reciprocal (count < 2048): floor(c*3277 >> 14).
    logic [CNT_BITS+13:0] div5_prod;
    cnt_t n_cut;
    assign div5_prod = count_reg * 12'd3277;
    always_comb
    begin
        n_cut = div5_prod[CNT_BITS+13 -: CNT_BITS];
        if (n_cut > cnt_t'(1000))
        begin
            n_cut = cnt_t'(1000);
        end
    end

    always_comb
    begin
        req = '0;
        unique case (state_reg)
            S_PR_RD, S_AK_RD0, S_SL_RD:
            begin
                req.rd_en = 1'b1;
                req.rd_addr = head_reg;
            end
            S_PS_RD, S_FD_RD:
            begin
                req.rd_en = 1'b1;
                req.rd_addr = slot(head_reg, i_reg);
            end
            S_SH_RD:
            begin
                req.rd_en = 1'b1;
                req.rd_addr = slot(head_reg, i_reg - cnt_t'(1));
            end
            S_SH_WR:
            begin
                req.wr_en = 1'b1;
                req.wr_addr = slot(head_reg, i_reg);
                req.wr_key = rd_key;
                req.wr_acked = rd_acked;
            end
            S_INS:
            begin
                req.wr_en = 1'b1;
                req.wr_addr = slot(head_reg, sp_reg);
                req.wr_key = k_reg;
                req.wr_acked = 1'b0;
            end
            S_MK_RD:
            begin
                req.rd_en = 1'b1;
                req.rd_addr = slot(head_reg, i_reg);
            end
            S_MK_WR:
            begin
                req.wr_en = 1'b1;
                req.wr_addr = slot(head_reg, i_reg);
                req.wr_key = rd_key;
                req.wr_acked = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ws_reg <= WS_BITS'(1024);
            head_reg <= '0;
            count_reg <= '0;
            done_reg <= 1'b0;
            i_reg <= '0;
            sp_reg <= '0;
            ep_reg <= '0;
            fnd_s_reg <= 1'b0;
            fnd_e_reg <= 1'b0;
            scan_e_reg <= 1'b0;
            func_reg <= 1'b0;
            k_reg <= '0;
            s_reg <= '0;
            status_reg <= ST_OK;
            valid_reg <= 1'b0;
            acked_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                ws_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        func_reg <= func;
                        k_reg <= offset;
                        s_reg <= start_offset;
                        status_reg <= ST_OK;
                        valid_reg <= 1'b0;
                        acked_reg <= '0;
                        i_reg <= '0;
                        if (func == FUNC_PUSH)
                        begin
                            state_reg <= (cnt10 >= ws9) ? S_PR_RD : S_PS_RD;
                        end
                        else if (start_offset > offset)
                        begin
                            status_reg <= ST_ACK_FAIL;
                            state_reg <= S_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            valid_reg <= 1'b1;
                            acked_reg <= offset;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_AK_RD0;
                        end
                    end
                end
                S_PR_RD:
                begin
                    state_reg <= (count_reg == '0) ? S_PR_CUT : S_PR_CHK;
                end
                S_PR_CHK:
                begin
                    if (rd_acked)
                    begin
                        head_reg <= head_reg + idx_t'(1);
                        count_reg <= count_reg - cnt_t'(1);
                        state_reg <= S_PR_RD;
                    end
                    else
                    begin
                        state_reg <= S_PR_CUT;
                    end
                end
                S_PR_CUT:
                begin
                    if (cnt5 >= ws4)
                    begin
                        count_reg <= count_reg - n_cut;
                    end
                    state_reg <= S_PS_RD;
                end
                S_PS_RD:
                begin
                    if (i_reg >= count_reg)
                    begin
                        sp_reg <= i_reg;
                        if (count_reg >= cnt_t'(STORE_DEPTH))
                        begin
                            status_reg <= ST_FULL;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            i_reg <= count_reg;
                            state_reg <= S_INS;
                        end
                    end
                    else
                    begin
                        state_reg <= S_PS_CHK;
                    end
                end
                S_PS_CHK:
                begin
                    if (rd_key < k_reg)
                    begin
                        i_reg <= i_reg + cnt_t'(1);
                        state_reg <= S_PS_RD;
                    end
                    else
                    begin
                        sp_reg <= i_reg;
                        if (rd_key == k_reg)
                        begin
                            state_reg <= S_INS;
                        end
                        else if (count_reg >= cnt_t'(STORE_DEPTH))
                        begin
                            status_reg <= ST_FULL;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            i_reg <= count_reg;
                            count_reg <= count_reg + cnt_t'(1);
                            state_reg <= (count_reg > i_reg) ? S_SH_RD : S_INS;
                        end
                    end
                end
                S_SH_RD:
                begin
                    state_reg <= S_SH_WR;
                end
                S_SH_WR:
                begin
                    i_reg <= i_reg - cnt_t'(1);
                    state_reg <= (i_reg - cnt_t'(1) > sp_reg) ? S_SH_RD : S_INS;
                end
                S_INS:
                begin
                    // Append at the end counts here; in-place and shifted
                    // inserts were counted already.
                    if (sp_reg == count_reg)
                    begin
                        count_reg <= count_reg + cnt_t'(1);
                    end
                    state_reg <= S_DONE;
                end
                S_AK_RD0:
                begin
                    state_reg <= S_AK_CHK0;
                end
                S_AK_CHK0:
                begin
                    if (k_reg < rd_key)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        i_reg <= '0;
                        fnd_s_reg <= 1'b0;
                        fnd_e_reg <= 1'b0;
                        scan_e_reg <= 1'b0;
                        state_reg <= S_FD_RD;
                    end
                end
                S_FD_RD:
                begin
                    if (i_reg >= count_reg)
                    begin
                        if (scan_e_reg)
                        begin
                            state_reg <= S_RANGE;
                        end
                        else
                        begin
                            scan_e_reg <= 1'b1;
                            i_reg <= '0;
                        end
                    end
                    else
                    begin
                        state_reg <= S_FD_CHK;
                    end
                end
                S_FD_CHK:
                begin
                    i_reg <= i_reg + cnt_t'(1);
                    state_reg <= S_FD_RD;
                    if (!scan_e_reg && rd_key == s_reg)
                    begin
                        fnd_s_reg <= 1'b1;
                        sp_reg <= i_reg;
                        scan_e_reg <= 1'b1;
                        i_reg <= '0;
                    end
                    else if (scan_e_reg && rd_key == k_reg)
                    begin
                        fnd_e_reg <= 1'b1;
                        ep_reg <= i_reg;
                        state_reg <= S_RANGE;
                    end
                end
                S_RANGE:
                begin
                    if (!fnd_s_reg && !fnd_e_reg)
                    begin
                        status_reg <= ST_ACK_FAIL;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (!fnd_s_reg)
                        begin
                            sp_reg <= '0;
                        end
                        if (!fnd_e_reg)
                        begin
                            ep_reg <= count_reg - cnt_t'(1);
                        end
                        i_reg <= fnd_s_reg ? sp_reg : '0;
                        state_reg <= S_MK_RD;
                    end
                end
                S_MK_RD:
                begin
                    state_reg <= (i_reg > ep_reg) ? S_SL_RD : S_MK_WR;
                end
                S_MK_WR:
                begin
                    i_reg <= i_reg + cnt_t'(1);
                    state_reg <= S_MK_RD;
                end
                S_SL_RD:
                begin
                    state_reg <= (count_reg == '0) ? S_DONE : S_SL_CHK;
                end
                S_SL_CHK:
                begin
                    if (rd_acked)
                    begin
                        acked_reg <= rd_key;
                        valid_reg <= 1'b1;
                        head_reg <= head_reg + idx_t'(1);
                        count_reg <= count_reg - cnt_t'(1);
                        state_reg <= S_SL_RD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign done = done_reg;
    assign status = status_reg;
    assign acked_valid = valid_reg;
    assign confirmed_offset = acked_reg;
    assign occupancy = count_reg;
    assign remaining = ({1'b0, ws_reg} > {1'b0, count_reg}) ?
        WS_BITS'(ws_reg - count_reg) : '0;

    `SAW_ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, count_reg <= cnt_t'(STORE_DEPTH), "count overflow")
    `SAW_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done longer than one cycle")
    `SAW_ASSERT_IMPL(a_done_idle, clk, rst_n, done, state_reg == S_IDLE, "done while busy")
    `SAW_ASSERT_IMPL(a_valid_ok, clk, rst_n, done && acked_valid, status == ST_OK, "valid with error")
endmodule
